// ----- src/ghalloc_pkg.sv -----
// types, codes and constants shared by the handle allocator modules
// no dependencies
package ghalloc_pkg;

    // request codes carried in the func field
    localparam logic [2:0] FUNC_ALLOC    = 3'd0;
    localparam logic [2:0] FUNC_RESERVE  = 3'd1;
    localparam logic [2:0] FUNC_FINALIZE = 3'd2;
    localparam logic [2:0] FUNC_DESTROY  = 3'd3;
    localparam logic [2:0] FUNC_CHECK    = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_FULL         = 3'd1;
    localparam logic [2:0] ST_STALE        = 3'd2;
    localparam logic [2:0] ST_NOT_RESERVED = 3'd3;
    localparam logic [2:0] ST_LOCKED       = 3'd4;

    // largest generation before wrapping back to 1
    localparam logic [30:0] GEN_MAX   = 31'h7FFF_FFFF;
    localparam logic [30:0] GEN_FRESH = 31'd1;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] handle_index;
        logic [31:0] handle_generation;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  out_index;
        logic [30:0] out_generation;
        logic        is_live;
    } out_item_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_EXEC
    } ctrl_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec_fire;
    } ctrl_cmd_t;

endpackage

// ----- src/ghalloc_ctrl.sv -----
// controller state machine for the handle allocator: handshakes and sequencing
// depends on ghalloc_pkg
module ghalloc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ghalloc_pkg::ctrl_cmd_t cmd
);

    ghalloc_pkg::ctrl_state_t state_reg, state_next;
    logic                     m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ghalloc_pkg::CTRL_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd.capture   = 1'b0;
        cmd.exec_fire = 1'b0;
        s_ready       = (state_reg == ghalloc_pkg::CTRL_IDLE);
        unique case (state_reg)
            ghalloc_pkg::CTRL_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ghalloc_pkg::CTRL_EXEC;
                end
            end
            ghalloc_pkg::CTRL_EXEC: begin
                // write back only once the output register can take the result
                if (!m_valid_reg || m_ready) begin
                    cmd.exec_fire = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ghalloc_pkg::CTRL_IDLE;
                end
            end
            default: begin
                state_next = ghalloc_pkg::CTRL_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- src/ghalloc_dp.sv -----
// datapath for the handle allocator: slot table, free list, fill count, result register
// depends on ghalloc_pkg
module ghalloc_dp #(
    parameter int SLOTS = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ghalloc_pkg::ctrl_cmd_t cmd,
    input  ghalloc_pkg::in_item_t  s_item,
    input  logic                   lock,
    output ghalloc_pkg::out_item_t m_item
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = IDX_W + 1;

    typedef struct packed {
        logic [30:0]      gen;
        logic             live;
        logic             rsv;
        logic [IDX_W-1:0] next;
    } entry_t;

    // slot table, one read-modify-write per item
    entry_t mem [SLOTS];
    entry_t rd_reg;

    ghalloc_pkg::in_item_t  req_reg;
    logic                   in_range_reg;
    ghalloc_pkg::out_item_t out_reg, out_next;

    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic             free_ne_reg, free_ne_next;
    logic [CNT_W-1:0] used_reg, used_next;

    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             cur;
    logic [IDX_W-1:0] hidx;

    assign hidx  = req_reg.handle_index[IDX_W-1:0];
    assign raddr = (s_item.func == ghalloc_pkg::FUNC_ALLOC ||
                    s_item.func == ghalloc_pkg::FUNC_RESERVE)
                   ? free_head_reg : s_item.handle_index[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_reg       <= mem[raddr];
            req_reg      <= s_item;
            // entries below the fill count have all been written
            in_range_reg <= (s_item.handle_index < 32'(used_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec_fire) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            free_ne_reg   <= 1'b0;
            used_reg      <= '0;
        end else begin
            free_head_reg <= free_head_next;
            free_ne_reg   <= free_ne_next;
            used_reg      <= used_next;
        end
    end

    assign cur = !req_reg.handle_generation[31] && in_range_reg && rd_reg.live &&
                 (rd_reg.gen == req_reg.handle_generation[30:0]);

    always_comb begin
        free_head_next = free_head_reg;
        free_ne_next   = free_ne_reg;
        used_next      = used_reg;
        we             = 1'b0;
        waddr          = hidx;
        wdata          = rd_reg;
        out_next       = '0;
        unique case (req_reg.func)
            ghalloc_pkg::FUNC_ALLOC, ghalloc_pkg::FUNC_RESERVE: begin
                wdata.live = 1'b1;
                wdata.rsv  = (req_reg.func == ghalloc_pkg::FUNC_RESERVE);
                if (free_ne_reg) begin
                    // pop the head; a self link marks the tail
                    waddr          = free_head_reg;
                    we             = 1'b1;
                    wdata.gen      = (rd_reg.gen == ghalloc_pkg::GEN_MAX)
                                     ? ghalloc_pkg::GEN_FRESH : rd_reg.gen + 31'd1;
                    free_head_next = rd_reg.next;
                    free_ne_next   = (rd_reg.next != free_head_reg);
                    out_next.out_index      = 10'(free_head_reg);
                    out_next.out_generation = wdata.gen;
                end else if (used_reg != CNT_W'(SLOTS)) begin
                    waddr      = used_reg[IDX_W-1:0];
                    we         = 1'b1;
                    wdata.gen  = ghalloc_pkg::GEN_FRESH;
                    wdata.next = used_reg[IDX_W-1:0];
                    used_next  = used_reg + CNT_W'(1);
                    out_next.out_index      = 10'(used_reg[IDX_W-1:0]);
                    out_next.out_generation = ghalloc_pkg::GEN_FRESH;
                end else begin
                    out_next.status = ghalloc_pkg::ST_FULL;
                end
            end
            ghalloc_pkg::FUNC_FINALIZE: begin
                if (!cur) begin
                    out_next.status = ghalloc_pkg::ST_STALE;
                end else if (!rd_reg.rsv) begin
                    out_next.status = ghalloc_pkg::ST_NOT_RESERVED;
                end else begin
                    we        = 1'b1;
                    wdata.rsv = 1'b0;
                end
            end
            ghalloc_pkg::FUNC_DESTROY: begin
                if (lock) begin
                    out_next.status = ghalloc_pkg::ST_LOCKED;
                end else if (!cur) begin
                    out_next.status = ghalloc_pkg::ST_STALE;
                end else begin
                    // push onto the free list head
                    we             = 1'b1;
                    wdata.live     = 1'b0;
                    wdata.rsv      = 1'b0;
                    wdata.next     = free_ne_reg ? free_head_reg : hidx;
                    free_head_next = hidx;
                    free_ne_next   = 1'b1;
                end
            end
            ghalloc_pkg::FUNC_CHECK: begin
                out_next.is_live = cur && !rd_reg.rsv;
            end
            default: begin
                out_next.status = ghalloc_pkg::ST_STALE;
            end
        endcase
        if (!cmd.exec_fire) begin
            we             = 1'b0;
            free_head_next = free_head_reg;
            free_ne_next   = free_ne_reg;
            used_next      = used_reg;
        end
    end

    assign m_item = out_reg;

endmodule

// ----- src/generational_handle_allocator_top.sv -----
// top level of the generational handle allocator
// depends on ghalloc_pkg, ghalloc_ctrl and ghalloc_dp
//
// Generational handle allocator. Hands out (index, generation) handles from a
// table of SLOTS slots and answers allocate, reserve, finalize, destroy and
// check requests, one result item per request item. Each item first reads the
// addressed slot entry from the single-port slot table (the free-list head for
// allocate and reserve, the handle's slot otherwise) and then updates and
// writes it back together with the free-list head and the fill count. Results
// leave through an output register, so the next item is accepted while an
// earlier result still waits on m_ready; a stalled result holds the write-back
// of the following item. Freed slots go on a LIFO free list, fresh slots come
// from a fill count, and slots at or above the fill count read as not live, so
// no clearing pass is needed after reset. The user must write the lock
// register through the cfg port only while idle; the block itself does not
// enforce this. When the lock is set, destroy answers locked.
module generational_handle_allocator_top #(
    parameter int SLOTS = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ghalloc_pkg::in_item_t  s_item,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output ghalloc_pkg::out_item_t m_item,
    // lock register write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);

    ghalloc_pkg::ctrl_cmd_t cmd;
    logic                   lock_reg;

    // lock register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            lock_reg <= cfg_data;
        end
    end

    // sequencing and handshakes
    ghalloc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // slot table, free list and result register
    ghalloc_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_item  (s_item),
        .lock    (lock_reg),
        .m_item  (m_item)
    );

    // an accepted item keeps the request side closed for its write-back cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while previous item still in flight");

    // table full results return a zero handle; non-allocating requests also do, unchecked here
    a_full_zero_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == ghalloc_pkg::ST_FULL) |->
        (m_item.out_index == 10'd0 && m_item.out_generation == 31'd0))
        else $error("table full result carries a handle");

    // a live answer only comes with ok status
    a_live_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.is_live) |-> (m_item.status == ghalloc_pkg::ST_OK))
        else $error("live answer with error status");

endmodule
